[src/elfr_pkg.sv]
// Shared types and constants of the ellipse fill rasterizer.
// No dependencies; imported by every module of the block.
package elfr_pkg;

    localparam int MAP_DIM_MAX = 1024;
    localparam int CW          = $clog2(MAP_DIM_MAX + 1); // map coordinate counter width
    localparam int SW          = 15;                      // signed working width for clipping
    localparam int CFG_W       = 11;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam int IN_XY_W     = 13;
    localparam int IN_WH_W     = 12;
    localparam int PIX_W       = 10;
    localparam int CEN_W       = 14;

    localparam int MUL_A_W     = 23;
    localparam int MUL_B_W     = 13;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int SQ_W        = 23;
    localparam int DSQ_W       = 2 * MUL_B_W;
    localparam int RP_W        = 46;
    localparam int ACC_W       = 50;
    localparam int HI_SH       = MUL_B_W;

    localparam int RECT_MIN    = 3;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] MAP_RESET = CFG_W'(1024);

    typedef struct packed {
        logic [CFG_W-1:0] map_width;
        logic [CFG_W-1:0] map_height;
    } cfg_t;

    // multiply-accumulate control, issued with the operands
    typedef struct packed {
        logic en;   // add the product into the accumulator
        logic clr;  // start a new sum
        logic hi;   // product weights the upper operand half
    } mac_ctl_t;

endpackage

[src/elfr_cfg.sv]
// APB register file: map_width and map_height.
// Depends on elfr_pkg.
module elfr_cfg import elfr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [CFG_W-1:0] map_width_reg;
    logic [CFG_W-1:0] map_height_reg;
    logic             reg_idx;
    logic             wr_en;

    assign reg_idx = paddr[2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= MAP_RESET;
            map_height_reg <= MAP_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MAP_WIDTH:  map_width_reg  <= pwdata[CFG_W-1:0];
                REG_MAP_HEIGHT: map_height_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAP_WIDTH:  prdata = APB_DW'(map_width_reg);
            REG_MAP_HEIGHT: prdata = APB_DW'(map_height_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.map_width  = map_width_reg;
    assign cfg.map_height = map_height_reg;

endmodule

[src/elfr_mac.sv]
// Shared 23x13 multiplier with a registered product and a shifting accumulator.
// Depends on elfr_pkg.
module elfr_mac import elfr_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  mac_ctl_t           ctl,
    input  logic [MUL_A_W-1:0] op_a,
    input  logic [MUL_B_W-1:0] op_b,
    output logic [PROD_W-1:0]  prod,
    output logic [ACC_W-1:0]   acc
);

    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    mac_ctl_t          ctl_reg;
    logic [ACC_W-1:0]  addend;

    // upper-half partial products carry a weight of 2^HI_SH
    assign addend = ctl_reg.hi ? (ACC_W'(prod_reg) << HI_SH) : ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl;
        end
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        if (ctl_reg.en) begin
            acc_reg <= (ctl_reg.clr ? '0 : acc_reg) + addend;
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

[src/ellipse_fill_rasterizer_unit.sv]
// Top level of the ellipse fill rasterizer: sequencer, clip and scan registers.
// Depends on elfr_pkg, elfr_cfg and elfr_mac.
//
// Input stream (s_*): one transaction per command. s_tuser is the command:
// start loads a bounding rectangle from s_tdata, step visits the next pixel
// of the clipped rectangle in raster order. Output stream (m_*): one
// transaction per step while a shape is active: pixel coordinates and the
// paint flag in m_tdata, m_tlast on the final pixel of the rectangle.
// Start transactions and steps while idle produce nothing.
// APB port: map_width at 0x0, map_height at 0x4; write only while idle.
// Timing: s_tready is high only in the idle state, so a new command waits
// until the previous one is through. After acceptance a start computes two
// squares and a two-pass product on the shared multiplier. A step runs six
// multiplier issues (dx^2, dy^2, and two halves for each weighted term),
// an accumulator drain state and the compare/output state. Steps of small
// rectangles (width or height below 3) skip the multiplier and go straight
// to the compare/output state.
// The result sits in an output register; the next command is accepted while
// it waits. If the receiver stalls, a new result holds in the compare cycle
// until the register frees. Reset idles the block, clears the active shape
// and sets both map sizes to 1024.
module ellipse_fill_rasterizer_unit import elfr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [55:0]       s_tdata,  // left[12:0], top[25:13], rect_w[37:26], rect_h[49:38]
    input  logic [0:0]        s_tuser,  // command[0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,  // pix_x[9:0], pix_y[19:10], paint[20]
    output logic              m_tlast,  // last
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQW,     // issue w*w
        ST_SQH,     // issue h*h, save w*w/4, clip
        ST_HH,      // save h*h/4
        ST_RP0,     // issue hw * hh low half
        ST_RP1,     // issue hw * hh high half
        ST_RPACC,   // accumulator drains
        ST_RPSAVE,  // save radius product
        ST_DX,      // issue dx*dx
        ST_DY,      // issue dy*dy, save dx^2
        ST_H0,      // issue hh * dx^2 low, save dy^2
        ST_H1,      // issue hh * dx^2 high
        ST_W0,      // issue hw * dy^2 low
        ST_W1,      // issue hw * dy^2 high
        ST_ACC,     // accumulator drains
        ST_OUT      // compare, emit result, advance scan
    } state_t;

    cfg_t cfg;

    elfr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mac_ctl_t           mac_ctl;
    logic [MUL_A_W-1:0] mac_a;
    logic [MUL_B_W-1:0] mac_b;
    logic [PROD_W-1:0]  mac_prod;
    logic [ACC_W-1:0]   mac_acc;

    elfr_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .prod    (mac_prod),
        .acc     (mac_acc)
    );

    state_t state_reg, state_next;

    // control
    logic active_reg;
    logic rect_mode_reg;
    logic m_tvalid_reg;

    // latched rectangle
    logic signed [IN_XY_W-1:0] left_reg;
    logic signed [IN_XY_W-1:0] top_reg;
    logic [IN_WH_W-1:0]        w_reg;
    logic [IN_WH_W-1:0]        h_reg;

    // shape
    logic signed [CEN_W-1:0]   center_x_reg;
    logic signed [CEN_W-1:0]   center_y_reg;
    logic [SQ_W-1:0]           half_w_sq_reg;
    logic [SQ_W-1:0]           half_h_sq_reg;
    logic [RP_W-1:0]           radius_product_reg;
    logic [CW-1:0]             col_first_reg;
    logic [CW-1:0]             col_end_reg;
    logic [CW-1:0]             row_end_reg;
    logic [CW-1:0]             cur_col_reg;
    logic [CW-1:0]             cur_row_reg;
    logic [DSQ_W-1:0]          dx_sq_reg;
    logic [DSQ_W-1:0]          dy_sq_reg;

    // output register
    logic [PIX_W-1:0]          pix_x_reg;
    logic [PIX_W-1:0]          pix_y_reg;
    logic                      paint_reg;
    logic                      last_reg;

    logic s_accept;
    logic out_free;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;

    // clip of the latched rectangle against the map
    logic signed [SW-1:0] left_s, top_s, wid_s, hgt_s;
    logic signed [SW-1:0] x_lo_s, y_lo_s, x_end_s, y_end_s, x_hi_s, y_hi_s;
    logic signed [SW-1:0] mw_s, mh_s;
    logic                 clip_ok;

    always_comb begin
        left_s  = SW'(left_reg);
        top_s   = SW'(top_reg);
        wid_s   = SW'(w_reg);
        hgt_s   = SW'(h_reg);
        mw_s    = SW'(cfg.map_width);
        mh_s    = SW'(cfg.map_height);
        if (mw_s > SW'(MAP_DIM_MAX)) mw_s = SW'(MAP_DIM_MAX);
        if (mh_s > SW'(MAP_DIM_MAX)) mh_s = SW'(MAP_DIM_MAX);
        x_lo_s  = left_s[SW-1] ? '0 : left_s;
        y_lo_s  = top_s[SW-1]  ? '0 : top_s;
        x_end_s = left_s + wid_s;
        y_end_s = top_s + hgt_s;
        x_hi_s  = (x_end_s > mw_s) ? mw_s : x_end_s;
        y_hi_s  = (y_end_s > mh_s) ? mh_s : y_end_s;
        clip_ok = (x_lo_s < x_hi_s) && (y_lo_s < y_hi_s);
    end

    // distance of the current pixel from the center
    logic signed [SW-1:0] col_s, row_s, cx_s, cy_s, dx_s, dy_s;
    logic [MUL_B_W-1:0]   dx_abs, dy_abs;

    always_comb begin
        col_s  = SW'(cur_col_reg);
        row_s  = SW'(cur_row_reg);
        cx_s   = SW'(center_x_reg);
        cy_s   = SW'(center_y_reg);
        dx_s   = col_s - cx_s;
        dy_s   = row_s - cy_s;
        dx_abs = dx_s[SW-1] ? MUL_B_W'(-dx_s) : MUL_B_W'(dx_s);
        dy_abs = dy_s[SW-1] ? MUL_B_W'(-dy_s) : MUL_B_W'(dy_s);
    end

    // scan position bookkeeping
    logic [CW:0] col_p1, row_p1;
    logic        col_done, row_done, pix_last, pix_paint;
    assign col_p1    = {1'b0, cur_col_reg} + 1'b1;
    assign row_p1    = {1'b0, cur_row_reg} + 1'b1;
    assign col_done  = col_p1 >= {1'b0, col_end_reg};
    assign row_done  = row_p1 >= {1'b0, row_end_reg};
    assign pix_last  = col_done & row_done;
    assign pix_paint = rect_mode_reg | (mac_acc <= ACC_W'(radius_product_reg));

    // sequencer and operand selection for the shared multiplier
    always_comb begin
        state_next = state_reg;
        mac_ctl    = '0;
        mac_a      = '0;
        mac_b      = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser[0] == CMD_START) begin
                        state_next = ST_SQW;
                    end else if (active_reg) begin
                        state_next = rect_mode_reg ? ST_OUT : ST_DX;
                    end
                end
            end
            ST_SQW: begin
                mac_a      = MUL_A_W'(w_reg);
                mac_b      = MUL_B_W'(w_reg);
                state_next = ST_SQH;
            end
            ST_SQH: begin
                mac_a      = MUL_A_W'(h_reg);
                mac_b      = MUL_B_W'(h_reg);
                state_next = ST_HH;
            end
            ST_HH: state_next = ST_RP0;
            ST_RP0: begin
                mac_a      = half_w_sq_reg;
                mac_b      = half_h_sq_reg[MUL_B_W-1:0];
                mac_ctl    = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
                state_next = ST_RP1;
            end
            ST_RP1: begin
                mac_a      = half_w_sq_reg;
                mac_b      = MUL_B_W'(half_h_sq_reg[SQ_W-1:MUL_B_W]);
                mac_ctl    = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
                state_next = ST_RPACC;
            end
            ST_RPACC:  state_next = ST_RPSAVE;
            ST_RPSAVE: state_next = ST_IDLE;
            ST_DX: begin
                mac_a      = MUL_A_W'(dx_abs);
                mac_b      = dx_abs;
                state_next = ST_DY;
            end
            ST_DY: begin
                mac_a      = MUL_A_W'(dy_abs);
                mac_b      = dy_abs;
                state_next = ST_H0;
            end
            ST_H0: begin
                mac_a      = half_h_sq_reg;
                mac_b      = dx_sq_reg[MUL_B_W-1:0];
                mac_ctl    = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
                state_next = ST_H1;
            end
            ST_H1: begin
                mac_a      = half_h_sq_reg;
                mac_b      = dx_sq_reg[DSQ_W-1:MUL_B_W];
                mac_ctl    = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
                state_next = ST_W0;
            end
            ST_W0: begin
                mac_a      = half_w_sq_reg;
                mac_b      = dy_sq_reg[MUL_B_W-1:0];
                mac_ctl    = '{en: 1'b1, clr: 1'b0, hi: 1'b0};
                state_next = ST_W1;
            end
            ST_W1: begin
                mac_a      = half_w_sq_reg;
                mac_b      = dy_sq_reg[DSQ_W-1:MUL_B_W];
                mac_ctl    = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
                state_next = ST_ACC;
            end
            ST_ACC: state_next = ST_OUT;
            ST_OUT: begin
                // hold here while the previous result is still unread
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            active_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // load a new result, else drop the one just taken
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept && s_tuser[0] == CMD_START) begin
                        left_reg   <= s_tdata[12:0];
                        top_reg    <= s_tdata[25:13];
                        w_reg      <= s_tdata[37:26];
                        h_reg      <= s_tdata[49:38];
                        active_reg <= 1'b0;
                    end
                end
                ST_SQH: begin
                    // product register holds w*w now
                    half_w_sq_reg <= mac_prod[SQ_W+1:2];
                    rect_mode_reg <= (w_reg < IN_WH_W'(RECT_MIN)) ||
                                     (h_reg < IN_WH_W'(RECT_MIN));
                    center_x_reg  <= CEN_W'(left_s + SW'(w_reg[IN_WH_W-1:1]));
                    center_y_reg  <= CEN_W'(top_s + SW'(h_reg[IN_WH_W-1:1]));
                    col_first_reg <= x_lo_s[CW-1:0];
                    cur_col_reg   <= x_lo_s[CW-1:0];
                    cur_row_reg   <= y_lo_s[CW-1:0];
                    col_end_reg   <= x_hi_s[CW-1:0];
                    row_end_reg   <= y_hi_s[CW-1:0];
                    active_reg    <= clip_ok;
                end
                ST_HH:     half_h_sq_reg      <= mac_prod[SQ_W+1:2];
                ST_RPSAVE: radius_product_reg <= mac_acc[RP_W-1:0];
                ST_DY:     dx_sq_reg          <= mac_prod[DSQ_W-1:0];
                ST_H0:     dy_sq_reg          <= mac_prod[DSQ_W-1:0];
                ST_OUT: begin
                    if (out_free) begin
                        pix_x_reg    <= PIX_W'(cur_col_reg);
                        pix_y_reg    <= PIX_W'(cur_row_reg);
                        paint_reg    <= pix_paint;
                        last_reg     <= pix_last;
                        if (pix_last) begin
                            active_reg <= 1'b0;
                        end else if (col_done) begin
                            cur_col_reg <= col_first_reg;
                            cur_row_reg <= row_p1[CW-1:0];
                        end else begin
                            cur_col_reg <= col_p1[CW-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, paint_reg, pix_y_reg, pix_x_reg};
    assign m_tlast  = last_reg;

endmodule
